@@ hdl/ring_modulator_highpass_core_defines.svh @@
// ----------------------------------------------------------------------------
// ring modulator highpass assertion macros
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef RING_MODULATOR_HIGHPASS_CORE_DEFINES_SVH
`define RING_MODULATOR_HIGHPASS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define RMHP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rmhp assertion failed");

// same-cycle implication outside reset
`define RMHP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmhp implication failed");

// next-cycle implication outside reset
`define RMHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmhp next-cycle implication failed");

`else

`define RMHP_ASSERT(lbl, clk, rst_n, prop)
`define RMHP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RMHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/rmhp_pkg.sv @@
// ----------------------------------------------------------------------------
// rmhp_pkg
// constants, register indexes and sine table generator for the ring modulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmhp_pkg;

  localparam int PHASE_BITS_DEF      = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 2'd2;

  // waveform codes
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  // reset values
  localparam logic [15:0] PHASE_STEP_RST   = 16'd1486;
  localparam logic [1:0]  WAVEFORM_RST     = WAVE_SINE;
  localparam logic [15:0] FILTER_COEFF_RST = 16'd65000;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // sine table entry k in q1.15, quarter-wave taylor series in q2.30
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned tb);
    int unsigned     qb;
    int unsigned     quad;
    int unsigned     r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          mag;
    qb   = tb - 2;
    quad = (k >> qb) & 3;
    r    = k & ((1 << qb) - 1);
    if ((quad & 1) != 0) begin
      r = (1 << qb) - r;
    end
    x  = (PI_HALF_Q30 * longint'(r)) >> qb;
    x2 = (x * x) >> 30;
    s  = longint'(x);
    t  = x;
    t  = ((t * x2) >> 30) / 6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 110;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 156;
    s  = s + longint'(t);
    if (s < 0) begin
      s = 0;
    end
    if (s > (64'sd1 <<< 30)) begin
      s = 64'sd1 <<< 30;
    end
    mag = (s + 64'sd16384) >>> 15;
    if (mag > 32767) begin
      mag = 32767;
    end
    if ((quad & 2) != 0) begin
      mag = -mag;
    end
    return 16'(mag);
  endfunction

endpackage

`default_nettype wire

@@ hdl/ring_modulator_highpass_core.sv @@
// ----------------------------------------------------------------------------
// ring_modulator_highpass_core
// stereo ring modulator with a one-pole highpass per channel
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o with left_sample_i, right_sample_i
//   output channel: out_valid_o / out_ready_i with left_out_o, right_out_o
//   config port: cfg_we_i, cfg_index_i, cfg_data_i; 0 phase step,
//     1 waveform, 2 filter coefficient; other indexes are ignored
//   one stereo item in gives one stereo item out
//   each item passes the steps MXL, MXR, MDL, MDR and FIN before its result
//     is loaded into the output register; the single shared multiplier does
//     four products per item (two modulations, two filter products)
//   the block takes one item at a time; in_ready_o is high only while idle
//   a finished result waits in the output register; while the receiver
//     stalls, the next item is already taken and worked on and holds in its
//     last step until the output register is free
//   reset clears phase, both filter histories, the handshakes and loads the
//     register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ring_modulator_highpass_core_defines.svh"

module ring_modulator_highpass_core #(
  parameter int PHASE_BITS      = rmhp_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = rmhp_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [rmhp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rmhp_pkg::CFG_W-1:0]   cfg_data_i,
  // input items
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [15:0]           left_sample_i,
  input  wire logic signed [15:0]           right_sample_i,
  // result items
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [15:0]                left_out_o,
  output logic signed [15:0]                right_out_o
);

  localparam int SINE_DEPTH = 2 ** SINE_TABLE_BITS;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_MXL  = 3'd1;  // left sample times gain
  localparam logic [2:0] S_MXR  = 3'd2;  // right sample times gain
  localparam logic [2:0] S_MDL  = 3'd3;  // left filter product
  localparam logic [2:0] S_MDR  = 3'd4;  // right filter product, left update
  localparam logic [2:0] S_FIN  = 3'd5;  // right update, load output

  // configuration registers
  logic [15:0] phase_step_q;
  logic [1:0]  waveform_q;
  logic [15:0] filter_coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= rmhp_pkg::PHASE_STEP_RST;
      waveform_q     <= rmhp_pkg::WAVEFORM_RST;
      filter_coeff_q <= rmhp_pkg::FILTER_COEFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rmhp_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        rmhp_pkg::REG_WAVEFORM:     waveform_q     <= cfg_data_i[1:0];
        rmhp_pkg::REG_FILTER_COEFF: filter_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshakes and state
  logic [2:0] state_q, state_d;
  logic       in_accept;
  logic       out_free;
  logic       out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // phase accumulator, advanced as the item is taken
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS-1:0] phase_d;

  assign step_ext = PHASE_BITS'(phase_step_q);
  assign phase_d  = phase_q + step_ext;

  // sine rom, read with the new phase at accept
  logic signed [15:0]          sine_rom [SINE_DEPTH];
  logic [SINE_TABLE_BITS-1:0]  sine_idx;
  logic signed [15:0]          sine_q;

  for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = rmhp_pkg::sine_entry(k, SINE_TABLE_BITS);
  end

  if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_idx_top
    assign sine_idx = phase_d[PHASE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_shift
    assign sine_idx = {phase_d, {(SINE_TABLE_BITS-PHASE_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sine_q <= sine_rom[sine_idx];
    end
  end

  // phase scaled to 16 bits for the sawtooth
  logic [15:0] p16;

  if (PHASE_BITS >= 16) begin : g_p16_top
    assign p16 = phase_q[PHASE_BITS-1 -: 16];
  end else begin : g_p16_shift
    assign p16 = {phase_q, {(16-PHASE_BITS){1'b0}}};
  end

  // gain select
  logic signed [15:0] gain;

  always_comb begin
    case (waveform_q)
      rmhp_pkg::WAVE_SINE:   gain = sine_q;
      rmhp_pkg::WAVE_SAW:    gain = {~p16[15], p16[14:0]};
      rmhp_pkg::WAVE_SQUARE: gain = phase_q[PHASE_BITS-1] ? 16'sh8000 : 16'sh7fff;
      default:               gain = '0;  // unused code mutes the carrier
    endcase
  end

  // latched samples and per-channel state
  logic signed [15:0] left_q, right_q;
  logic signed [24:0] x_l_q, x_r_q;      // modulated samples, 2^-23 units
  logic signed [23:0] hist_l_q, hist_r_q;
  logic signed [15:0] y_l_q;

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] prod_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MXL: begin
        mul_a = 26'(left_q);
        mul_b = 17'(gain);
      end
      S_MXR: begin
        mul_a = 26'(right_q);
        mul_b = 17'(gain);
      end
      S_MDL: begin
        mul_a = 26'(hist_l_q) - 26'(x_l_q);
        mul_b = {1'b0, filter_coeff_q};
      end
      S_MDR: begin
        mul_a = 26'(hist_r_q) - 26'(x_r_q);
        mul_b = {1'b0, filter_coeff_q};
      end
      default: ;
    endcase
  end

  // the right filter product stays put while the result waits
  always_ff @(posedge clk_i) begin
    if (state_q != S_FIN) begin
      prod_q <= 43'(mul_a) * 43'(mul_b);
    end
  end

  // modulated sample, rounded from 2^-30 units
  logic signed [42:0] x_sum;
  logic signed [24:0] x_new;

  assign x_sum = prod_q + 43'sd64;
  assign x_new = x_sum[31:7];

  // lowpass update and highpass output for the channel in its last step
  logic signed [24:0] x_sel;
  logic signed [42:0] r_sum;
  logic signed [26:0] r16;
  logic signed [27:0] lp_full;
  logic signed [23:0] lp_clamp;
  logic signed [25:0] diff;
  logic signed [25:0] y_sum;
  logic signed [17:0] y_sh;
  logic signed [15:0] y_sat;

  assign x_sel   = (state_q == S_MDR) ? x_l_q : x_r_q;
  assign r_sum   = prod_q + 43'sd32768;
  assign r16     = r_sum[42:16];
  assign lp_full = 28'(x_sel) + 28'(r16);

  always_comb begin
    if (lp_full > 28'sd8388607) begin
      lp_clamp = 24'sh7fffff;
    end else if (lp_full < -28'sd8388608) begin
      lp_clamp = 24'sh800000;
    end else begin
      lp_clamp = lp_full[23:0];
    end
  end

  assign diff  = 26'(x_sel) - 26'(lp_clamp);
  assign y_sum = diff + 26'sd128;
  assign y_sh  = y_sum[25:8];

  always_comb begin
    if (y_sh > 18'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_sh < -18'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sh[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_accept) state_d = S_MXL;
      S_MXL:  state_d = S_MXR;
      S_MXR:  state_d = S_MDL;
      S_MDL:  state_d = S_MDR;
      S_MDR:  state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      hist_l_q    <= '0;
      hist_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        phase_q <= phase_d;
      end
      if (state_q == S_MDR) begin
        hist_l_q <= lp_clamp;
      end
      if (state_q == S_FIN && out_free) begin
        hist_r_q    <= lp_clamp;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
    end
    if (state_q == S_MXR) begin
      x_l_q <= x_new;
    end
    if (state_q == S_MDL) begin
      x_r_q <= x_new;
    end
    if (state_q == S_MDR) begin
      y_l_q <= y_sat;
    end
    if (state_q == S_FIN && out_free) begin
      left_out_o  <= y_l_q;
      right_out_o <= y_sat;
    end
  end

  // assertions
  `RMHP_ASSERT_NEXT(a_idle_holds, clk_i, rst_ni, (state_q == S_IDLE) && !in_accept, state_q == S_IDLE)
  `RMHP_ASSERT_NEXT(a_phase_step, clk_i, rst_ni, in_accept, phase_q == $past(phase_d))
  `RMHP_ASSERT_IMPLY(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == S_FIN)
  `RMHP_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(in_accept && (state_q != S_IDLE)))

endmodule

`default_nettype wire

@@ sim/ring_modulator_highpass_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_modulator_highpass_core testbench
// drives stereo items through the ring modulator under random idling and
// back-pressure, predicts every result in a local model of the oscillator,
// mixer and per-channel highpass, and compares each result field by field
// ----------------------------------------------------------------------------

module ring_modulator_highpass_core_tb;

  import rmhp_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 1000000;
  // extra wait once every result is back, as margin for the block to settle
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 250;
  localparam int PHASE_COUNT   = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int PRINT_CAP     = 40;

  // codes the package leaves unnamed
  localparam logic [1:0]           WAVE_OFF   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = -16'sh8000;

  localparam longint LP_MAX = 64'sd8388607;
  localparam longint LP_MIN = -64'sd8388608;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  // dut signals
  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  // local copy of the block's registers and state
  logic [15:0] cfg_step;
  logic [1:0]  cfg_wave;
  logic [15:0] cfg_coeff;
  logic [15:0] osc_phase;
  longint      hist_left;
  longint      hist_right;

  stereo_t filtered_q[$];

  // idling controls shared with the receiver
  bit gaps_on;
  bit stalls_on;
  int hold_req;
  int stall_cnt;

  int items_sent;
  int results_seen;
  int mismatches;
  int reg_writes;
  int holds_done;
  int cycle_count;

  ring_modulator_highpass_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .left_out_o     (left_out),
    .right_out_o    (right_out)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // quarter-wave taylor sine in q2.30, folded into four quadrants
  function automatic int sine_q15(input logic [9:0] idx);
    longint unsigned xr;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          mag;
    int unsigned     r;
    int unsigned     n;
    r = idx[7:0];
    if (idx[8]) begin
      r = 256 - r;
    end
    t  = r;
    xr = (PI_HALF_Q30 * t) >> 8;
    x2 = (xr * xr) >> 30;
    s  = xr;
    t  = xr;
    for (n = 1; n < 13; n += 2) begin
      t = ((t * x2) >> 30) / ((n + 1) * (n + 2));
      if (n % 4 == 1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > (64'sd1 <<< 30)) begin
      s = 64'sd1 <<< 30;
    end
    mag = (s + 64'sd16384) >>> 15;
    // a full-scale peak does not fit q1.15
    if (mag > 32767) begin
      mag = 32767;
    end
    return idx[9] ? -int'(mag) : int'(mag);
  endfunction

  function automatic int osc_gain(input logic [15:0] ph);
    int g;
    case (cfg_wave)
      WAVE_SINE: g = sine_q15(ph[15:6]);
      WAVE_SAW: begin
        g = ph;
        g = g - 32768;
      end
      WAVE_SQUARE: g = ph[15] ? -32768 : 32767;
      default: g = 0;
    endcase
    return g;
  endfunction

  // mix with the gain, then out = x - lp where lp tracks the history
  function automatic logic signed [15:0] highpass_channel(
      input logic signed [15:0] smp, input int gain,
      input longint hist_in, output longint hist_out);
    longint x;
    longint d;
    longint lp;
    longint y;
    longint cf;
    cf = cfg_coeff;
    x  = (longint'(smp) * longint'(gain) + 64) >>> 7;
    d  = hist_in - x;
    lp = x + ((d * cf + 32768) >>> 16);
    if (lp > LP_MAX) begin
      lp = LP_MAX;
    end
    if (lp < LP_MIN) begin
      lp = LP_MIN;
    end
    hist_out = lp;
    y = (x - lp + 128) >>> 8;
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    return y[15:0];
  endfunction

  function automatic stereo_t modulate_and_filter(input logic signed [15:0] l,
                                                  input logic signed [15:0] r);
    stereo_t res;
    int      gain;
    longint  nh;
    osc_phase = osc_phase + cfg_step;
    gain      = osc_gain(osc_phase);
    res.left  = highpass_channel(l, gain, hist_left, nh);
    hist_left = nh;
    res.right = highpass_channel(r, gain, hist_right, nh);
    hist_right = nh;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // helpers
  // ------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return S_MIN;
      1: return S_MAX;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    mismatches++;
  endtask

  // one item on the input channel; the prediction is queued on acceptance
  task automatic send_item(input logic signed [15:0] l, input logic signed [15:0] r);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk_i); while (!in_ready);
    filtered_q.push_back(modulate_and_filter(l, r));
    items_sent++;
  endtask

  // sender stops until every result is back and the block has settled
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PHASE_STEP:   cfg_step  = val;
      REG_WAVEFORM:     cfg_wave  = val[1:0];
      REG_FILTER_COEFF: cfg_coeff = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // receiver and result check
  // ------------------------------------------------------------------------

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        // long hold-off so the block fills up and stalls its input
        out_ready <= 1'b0;
        hold_req--;
      end else if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 2) == 0) begin
          stall_cnt = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    stereo_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = filtered_q.pop_front();
        if (want.left != left_out) begin
          report_mismatch($sformatf("left_out expected %0d got %0d", want.left, left_out));
        end
        if (want.right != right_out) begin
          report_mismatch($sformatf("right_out expected %0d got %0d", want.right,
                                    right_out));
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // default registers straight out of reset: sine, reset step and coefficient
  task automatic test_reset_values();
    send_item(S_MIN, S_MAX);
    send_item(S_MAX, S_MIN);
    send_item(16'sd0, 16'sd0);
    send_item(-16'sd1, 16'sd1);
  endtask

  // quarter-cycle step walks the carrier through all four quadrants;
  // the unused waveform code must give silence into the still running filter
  task automatic test_each_waveform();
    logic [1:0] waves[4];
    int         i;
    waves = '{WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_OFF};
    write_reg(REG_PHASE_STEP, 16'd16384);
    write_reg(REG_FILTER_COEFF, 16'hFFFF);
    for (i = 0; i < 4; i++) begin
      write_reg(REG_WAVEFORM, {14'd0, waves[i]});
      send_item(S_MAX, S_MIN);
      send_item(S_MIN, S_MAX);
      send_item(S_MAX, S_MAX);
      send_item(S_MIN, S_MIN);
    end
    // upper data bits are dropped: this selects the sawtooth
    write_reg(REG_WAVEFORM, 16'hFFFD);
    write_reg(REG_PHASE_STEP, 16'hFFFF);
    write_reg(REG_FILTER_COEFF, 16'd0);
    send_item(S_MAX, -16'sd1);
    send_item(16'sd1, S_MIN);
    // a write to the unused index must change nothing
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(S_MIN, 16'sd12345);
    send_item(-16'sd12345, S_MAX);
  endtask

  task automatic test_backpressure();
    int i;
    write_reg(REG_WAVEFORM, {14'd0, WAVE_SINE});
    write_reg(REG_FILTER_COEFF, 16'd65000);
    write_reg(REG_PHASE_STEP, 16'd1486);
    gaps_on  = 1'b0;
    hold_req = HOLD_CYCLES;
    holds_done++;
    for (i = 0; i < 12; i++) begin
      send_item(rand_sample(), rand_sample());
    end
    // pause until all outstanding results have drained
    wait_idle();
    gaps_on  = 1'b1;
    hold_req = HOLD_CYCLES;
    holds_done++;
    for (i = 0; i < 12; i++) begin
      send_item(rand_sample(), rand_sample());
    end
  endtask

  task automatic test_random_stream();
    int          ph;
    int          i;
    logic [15:0] step;
    logic [15:0] coeff;
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        1: begin
          step  = 16'd0;
          coeff = 16'd0;
        end
        2: begin
          step  = 16'hFFFF;
          coeff = 16'hFFFF;
        end
        default: begin
          step  = 16'($urandom());
          coeff = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(60000, 65535))
                                              : 16'($urandom());
        end
      endcase
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_FILTER_COEFF, coeff);
      write_reg(REG_WAVEFORM, 16'($urandom()));
      // first phase runs back to back with no idling on either side
      gaps_on   = (ph != 0);
      stalls_on = (ph != 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph % 3 == 1 && i == PHASE_ITEMS / 2) begin
          wait_idle();
        end
        send_item(rand_sample(), rand_sample());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin : main_seq
    int drain;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_PHASE_STEP;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_sample  = '0;
    right_sample = '0;
    out_ready    = 1'b0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    hold_req     = 0;
    stall_cnt    = 0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    reg_writes   = 0;
    holds_done   = 0;
    cfg_step     = PHASE_STEP_RST;
    cfg_wave     = WAVEFORM_RST;
    cfg_coeff    = FILTER_COEFF_RST;
    osc_phase    = '0;
    hist_left    = 0;
    hist_right   = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_each_waveform();
    test_backpressure();
    test_random_stream();

    @(negedge clk_i);
    in_valid <= 1'b0;
    drain = 0;
    while (filtered_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (filtered_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));
    end

    $display("%0d stereo items in, %0d results out, %0d register writes,",
             items_sent, results_seen, reg_writes);
    $display("all waveform codes, filter extremes and %0d long output hold-offs",
             holds_done);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
